[design/spat_pkg.sv]
// Shared types and constants for the station presence aging table.
// No dependencies; compiled first.
package spat_pkg;

   localparam int ADDR_W     = 48;
   localparam int LEN_W      = 12;
   localparam int TTL_W      = 16;
   localparam int OUT_CNT_W  = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int DEF_ENTRIES      = 64;
   localparam int DEF_HEADER_BYTES = 24;

   localparam logic [TTL_W-1:0] TTL_RESET = 16'd60;

   // func codes
   localparam logic FUNC_FRAME = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // register word index (paddr[CSR_ADDR_W-1:2])
   localparam logic [CSR_ADDR_W-3:0] REG_TTL_RELOAD = '0;

   typedef struct packed {
      logic              online;
      logic [TTL_W-1:0]  ttl;
      logic [ADDR_W-1:0] address;
   } entry_type;

   typedef struct packed {
      logic      we;
      logic      hit;
      logic      count_inc;
      logic      count_dec;
      entry_type data;
   } upd_type;

endpackage

[design/spat_if.sv]
// Handshake channels for request and response transactions.
// Depends on spat_pkg for field widths.
interface spat_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [spat_pkg::ADDR_W-1:0]    source_address;
   logic [spat_pkg::LEN_W-1:0]     frame_length;

   modport source(output valid, func, source_address, frame_length, input ready);
   modport sink(input valid, func, source_address, frame_length, output ready);
endinterface

interface spat_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [spat_pkg::OUT_CNT_W-1:0] online_count;
   logic                           frame_accepted;
   logic                           table_wrapped;

   modport source(output valid, online_count, frame_accepted, table_wrapped, input ready);
   modport sink(input valid, online_count, frame_accepted, table_wrapped, output ready);
endinterface

[design/spat_entry_update.sv]
// Per-entry modify step of the table walk: aging on ticks, match on frames.
// Depends on spat_pkg.
module spat_entry_update (
   input  logic                        is_tick,
   input  logic                        entry_valid,
   input  spat_pkg::entry_type         entry,
   input  logic [spat_pkg::ADDR_W-1:0] lookup_address,
   input  logic [spat_pkg::TTL_W-1:0]  ttl_reload,
   output spat_pkg::upd_type           upd
);
   import spat_pkg::*;

   always_comb begin
      upd           = '0;
      upd.data      = entry;
      if (entry_valid) begin
         if (is_tick) begin
            upd.we = 1'b1;
            if (entry.ttl <= TTL_W'(1)) begin
               upd.data.online = 1'b0;
               upd.data.ttl    = ttl_reload;
               upd.count_dec   = entry.online;
            end else begin
               upd.data.ttl = entry.ttl - TTL_W'(1);
            end
         end else if (entry.address == lookup_address) begin
            upd.we          = 1'b1;
            upd.hit         = 1'b1;
            upd.data.online = 1'b1;
            upd.data.ttl    = ttl_reload;
            upd.count_inc   = ~entry.online;
         end
      end
   end

endmodule

[design/station_presence_aging_table.sv]
// Station presence table with aging: tick and long-frame transactions walk all entries.
// Ticks and long frames walk the memory one entry per cycle; a frame miss then inserts,
// and a short frame skips the walk. A new transaction is taken only in idle, after the
// previous response has been registered; the finish state waits while an earlier response
// is held by back-pressure on the response channel.
// Reset (synchronous): clears fill count, pointer, online count, FSM and ttl_reload to 60.
// Table memory is not cleared; entries at or above the fill count read as invalid.
// Depends on spat_pkg, spat_if and spat_entry_update.
module station_presence_aging_table #(
   parameter int ENTRIES      = spat_pkg::DEF_ENTRIES,
   parameter int HEADER_BYTES = spat_pkg::DEF_HEADER_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   spat_req_if.sink                        req_ch,
   spat_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [spat_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [spat_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [spat_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import spat_pkg::*;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(ENTRIES + 1);
   // internal count wide enough for ENTRIES and for the 7-bit result field
   localparam int CNT_W  = (FILL_W > OUT_CNT_W) ? FILL_W : OUT_CNT_W;
   localparam int ENT_W  = $bits(entry_type);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [FILL_W-1:0] FULL     = FILL_W'(ENTRIES);
   localparam logic [LEN_W-1:0]  HDR_LEN  = LEN_W'(HEADER_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_INSERT = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // ---------------------------------------------------------------
   // Configuration: single ttl_reload register at word 0
   // ---------------------------------------------------------------
   logic [TTL_W-1:0] ttl_reload_ff, ttl_reload_in;
   logic             csr_hit;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_TTL_RELOAD);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(ttl_reload_ff) : '0;

   always_comb begin
      ttl_reload_in = ttl_reload_ff;
      if (csr_write && csr_hit) begin
         ttl_reload_in = csr_pwdata[TTL_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   state_type         state_ff, state_in;
   logic              issue_ff, issue_in;         // read port walking
   logic [IDX_W-1:0]  issue_idx_ff, issue_idx_in;
   logic              rd_vld_ff, rd_vld_in;       // read data valid this cycle
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              hit_ff, hit_in;
   logic              ptr_online_ff, ptr_online_in; // old entry at pointer online
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;           // entries below fill are valid
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // per-transaction payload (no reset)
   logic              func_ff, func_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              accepted_ff, accepted_in;
   logic              wrapped_ff, wrapped_in;

   // response payload registers
   logic [OUT_CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic                 rsp_wrap_ff, rsp_wrap_in;

   // ---------------------------------------------------------------
   // Table memory: {online, ttl, address}, one write and one read port
   // ---------------------------------------------------------------
   logic [ENT_W-1:0] mem [ENTRIES];
   entry_type        rd_q_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue_ff) begin
         rd_q_ff <= mem[issue_idx_ff];
      end
   end

   // ---------------------------------------------------------------
   // Entry modify step
   // ---------------------------------------------------------------
   upd_type upd;
   logic    rd_entry_valid;

   assign rd_entry_valid = (FILL_W'(rd_idx_ff) < fill_ff);

   spat_entry_update u_update (
      .is_tick       (func_ff == FUNC_TICK),
      .entry_valid   (rd_entry_valid),
      .entry         (rd_q_ff),
      .lookup_address(addr_ff),
      .ttl_reload    (ttl_reload_ff),
      .upd           (upd)
   );

   logic req_take;
   logic rsp_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid & req_ch.ready;
   assign rsp_free     = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      issue_idx_in  = issue_idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      ptr_online_in = ptr_online_ff;
      ptr_in        = ptr_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      func_in       = func_ff;
      addr_in       = addr_ff;
      accepted_in   = accepted_ff;
      wrapped_in    = wrapped_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_wrap_in   = rsp_wrap_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_idx_ff;
      mem_wdata     = upd.data;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in       = req_ch.func;
               addr_in       = req_ch.source_address;
               accepted_in   = (req_ch.func == FUNC_FRAME) && (req_ch.frame_length >= HDR_LEN);
               wrapped_in    = 1'b0;
               hit_in        = 1'b0;
               ptr_online_in = 1'b0;
               issue_idx_in  = '0;
               if ((req_ch.func == FUNC_TICK) || (req_ch.frame_length >= HDR_LEN)) begin
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  // short frame: nothing changes
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            // read side: one entry per cycle
            if (issue_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_idx_ff;
               if (issue_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + IDX_W'(1);
               end
            end
            // modify/write side, one entry behind the read
            if (rd_vld_ff) begin
               mem_we    = upd.we;
               mem_waddr = rd_idx_ff;
               mem_wdata = upd.data;
               hit_in    = hit_ff | upd.hit;
               if (upd.count_inc) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (upd.count_dec) begin
                  count_in = count_ff - CNT_W'(1);
               end
               if (rd_idx_ff == ptr_ff) begin
                  ptr_online_in = rd_entry_valid & rd_q_ff.online;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  if ((func_ff == FUNC_FRAME) && !(hit_ff | upd.hit)) begin
                     state_in = ST_INSERT;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end

         ST_INSERT: begin
            // miss: overwrite the entry at the round-robin pointer
            mem_we            = 1'b1;
            mem_waddr         = ptr_ff;
            mem_wdata.online  = 1'b1;
            mem_wdata.ttl     = ttl_reload_ff;
            mem_wdata.address = addr_ff;
            // old entry online -> count unchanged
            if (!ptr_online_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (fill_ff != FULL) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (ptr_ff == LAST_IDX) begin
               ptr_in     = '0;
               wrapped_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff[OUT_CNT_W-1:0];
               rsp_acc_in   = accepted_ff;
               rsp_wrap_in  = wrapped_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         issue_idx_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         rd_idx_ff     <= '0;
         hit_ff        <= 1'b0;
         ptr_online_ff <= 1'b0;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         ttl_reload_ff <= TTL_RESET;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         issue_idx_ff  <= issue_idx_in;
         rd_vld_ff     <= rd_vld_in;
         rd_idx_ff     <= rd_idx_in;
         hit_ff        <= hit_in;
         ptr_online_ff <= ptr_online_in;
         ptr_ff        <= ptr_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         ttl_reload_ff <= ttl_reload_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      addr_ff      <= addr_in;
      accepted_ff  <= accepted_in;
      wrapped_ff   <= wrapped_in;
      rsp_count_ff <= rsp_count_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_wrap_ff  <= rsp_wrap_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.online_count   = rsp_count_ff;
   assign rsp_ch.frame_accepted = rsp_acc_ff;
   assign rsp_ch.table_wrapped  = rsp_wrap_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_count_le_fill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(fill_ff))
      else $error("online count exceeds number of valid entries");

   a_insert_on_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> !hit_ff)
      else $error("insert after a hit");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("read data outside table walk");

   a_wrap_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_INSERT) && (ptr_ff == LAST_IDX)) |=> (fill_ff == FULL))
      else $error("pointer wrapped before table filled");

endmodule

[tb/station_presence_aging_table_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for station_presence_aging_table: frame and tick transactions,
// ttl_reload changes over the CSR port, every status response checked against a predictor.
// Depends on spat_pkg, spat_if and the design top level.
module station_presence_aging_table_test;
   import spat_pkg::*;

   localparam int ENTRIES      = DEF_ENTRIES;
   localparam int HEADER_BYTES = DEF_HEADER_BYTES;
   localparam int STALL_MAX    = 10;
   localparam int PHASE_ITEMS  = 150;
   localparam int POOL_DEPTH   = 96;        // a bit larger than the table, so some lookups miss
   localparam int DRAIN_CYCLES = DEF_ENTRIES + 8;
   localparam int IDLE_LIMIT   = 2000;     // ~20x the slowest transaction incl. both stalls
   localparam logic [LEN_W-1:0] MAX_LEN = '1;
   localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(DEF_HEADER_BYTES);
   // word index with no register behind it; writes there must be dropped
   localparam logic [CSR_ADDR_W-3:0] REG_UNMAPPED = '1;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] source_address;
      logic [LEN_W-1:0]  frame_length;
   } presence_item_t;

   typedef struct packed {
      logic [OUT_CNT_W-1:0] online_count;
      logic                 frame_accepted;
      logic                 table_wrapped;
   } presence_status_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   spat_req_if req_ch ();
   spat_rsp_if rsp_ch ();

   station_presence_aging_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the station table, updated at each request handshake
   // ------------------------------------------------------------------
   bit               shadow_valid  [ENTRIES];
   bit               shadow_online [ENTRIES];
   logic [ADDR_W-1:0] shadow_addr  [ENTRIES];
   logic [TTL_W-1:0]  shadow_ttl   [ENTRIES];
   int               shadow_ptr;
   logic [TTL_W-1:0] shadow_reload;

   presence_item_t   pending_items [$];    // filled by the stimulus block, drained by the driver
   presence_status_t expected_status [$];  // one per accepted request transaction
   logic [ADDR_W-1:0] addr_pool [$];       // recently seen stations, reused to force hits

   int mismatches;
   int n_frames, n_short, n_hits, n_ticks, n_wraps, n_checked, n_settings;

   // Applies one transaction to the shadow table, returns the status it must produce.
   function automatic presence_status_t age_or_learn(input presence_item_t it);
      presence_status_t st;
      bit               hit;
      int               online;
      st     = '0;
      hit    = 1'b0;
      online = 0;
      if (it.func == FUNC_TICK) begin
         n_ticks++;
         for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i]) begin
               // expiry (and a zero reload) drops the station offline and restarts its ttl
               if (shadow_ttl[i] <= 1) begin
                  shadow_online[i] = 1'b0;
                  shadow_ttl[i]    = shadow_reload;
               end else begin
                  shadow_ttl[i] = shadow_ttl[i] - 1'b1;
               end
            end
         end
      end else if (it.frame_length >= HDR_LEN) begin
         n_frames++;
         st.frame_accepted = 1'b1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && shadow_addr[i] == it.source_address) begin
               shadow_ttl[i]    = shadow_reload;
               shadow_online[i] = 1'b1;
               hit              = 1'b1;
            end
         end
         if (hit) begin
            n_hits++;
         end else begin
            // miss: round-robin overwrite at the insert pointer
            shadow_valid[shadow_ptr]  = 1'b1;
            shadow_addr[shadow_ptr]   = it.source_address;
            shadow_ttl[shadow_ptr]    = shadow_reload;
            shadow_online[shadow_ptr] = 1'b1;
            shadow_ptr++;
            if (shadow_ptr >= ENTRIES) begin
               shadow_ptr       = 0;
               st.table_wrapped = 1'b1;
               n_wraps++;
            end
         end
      end else begin
         n_short++;  // runt frame: no table change, flags stay low
      end
      for (int i = 0; i < ENTRIES; i++)
         if (shadow_valid[i] && shadow_online[i])
            online++;
      st.online_count = online[OUT_CNT_W-1:0];
      return st;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic check_status();
      presence_status_t want;
      if (expected_status.size() == 0) begin
         report_mismatch("response with no transaction outstanding",
                         64'(rsp_ch.online_count), 64'd0);
         return;
      end
      want = expected_status.pop_front();
      n_checked++;
      if (rsp_ch.online_count !== want.online_count)
         report_mismatch("online_count", 64'(rsp_ch.online_count), 64'(want.online_count));
      if (rsp_ch.frame_accepted !== want.frame_accepted)
         report_mismatch("frame_accepted", 64'(rsp_ch.frame_accepted),
                         64'(want.frame_accepted));
      if (rsp_ch.table_wrapped !== want.table_wrapped)
         report_mismatch("table_wrapped", 64'(rsp_ch.table_wrapped), 64'(want.table_wrapped));
   endtask

   // ------------------------------------------------------------------
   // Request driver: random gap after each transaction, occasional
   // back-to-back stretches
   // ------------------------------------------------------------------
   presence_item_t next_item;
   int             req_gap;
   bit             req_calm;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap      <= 0;
         req_calm     <= 1'b0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // hold the transaction until the table takes it
      end else if (req_gap != 0) begin
         req_ch.valid <= 1'b0;
         req_gap      <= req_gap - 1;
      end else if (pending_items.size() != 0) begin
         next_item                = pending_items.pop_front();
         req_ch.valid            <= 1'b1;
         req_ch.func             <= next_item.func;
         req_ch.source_address   <= next_item.source_address;
         req_ch.frame_length     <= next_item.frame_length;
         req_gap                 <= req_calm ? 0 : int'($urandom_range(0, STALL_MAX));
         if ($urandom_range(0, 39) == 0)
            req_calm <= !req_calm;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // request handshake -> predict
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         expected_status.push_back(age_or_learn({req_ch.func, req_ch.source_address,
                                                 req_ch.frame_length}));
   end

   // ------------------------------------------------------------------
   // Response monitor: checks each transaction, then may hold ready low for a random stall
   // ------------------------------------------------------------------
   int rsp_stall;
   int rsp_draw;
   bit rsp_calm;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
         rsp_calm     <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         check_status();
         rsp_draw      = rsp_calm ? 0 : int'($urandom_range(0, STALL_MAX));
         rsp_ch.ready <= (rsp_draw == 0);
         rsp_stall    <= (rsp_draw == 0) ? 0 : rsp_draw - 1;
         if ($urandom_range(0, 39) == 0)
            rsp_calm <= !rsp_calm;
      end else if (rsp_stall != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog: any handshake or CSR access counts as progress
   int idle_cycles;

   always @(posedge clock) begin
      if (reset || csr_psel || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_item(input logic func, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len);
      presence_item_t it;
      it.func           = func;
      it.source_address = addr;
      it.frame_length   = len;
      pending_items.push_back(it);
   endtask

   // table idle: nothing queued, nothing on the wire, every response back
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_status.size() != 0);
   endtask

   // APB write (setup + access), then read ttl_reload back and compare
   task automatic set_register(input logic [CSR_ADDR_W-3:0] index,
                               input logic [TTL_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_TTL_RELOAD) begin
         shadow_reload = value;
         n_settings++;
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {REG_TTL_RELOAD, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {{(CSR_DATA_W-TTL_W){1'b0}}, shadow_reload})
         report_mismatch("ttl_reload readback", 64'(readback), 64'(shadow_reload));
   endtask

   // Mostly well-formed frames, with a pool of known stations so lookups hit;
   // ticks and runt frames carry random noise in their ignored fields.
   task automatic queue_random_items(input int count);
      logic [63:0]       wide;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      int                pick;
      for (int k = 0; k < count; k++) begin
         wide = {$urandom, $urandom};
         addr = wide[ADDR_W-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            queue_item(FUNC_TICK, addr, wide[63:64-LEN_W]);
         end else if (pick < 35) begin
            len = LEN_W'($urandom_range(0, HEADER_BYTES - 1));
            queue_item(FUNC_FRAME, addr, len);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && addr_pool.size() != 0) begin
               addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            end else if (pick < 63) begin
               addr = '0;
            end else if (pick < 66) begin
               addr = '1;
            end else begin
               addr_pool.push_back(addr);
               if (addr_pool.size() > POOL_DEPTH)
                  void'(addr_pool.pop_front());
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
               len = HDR_LEN;
            else if (pick == 1)
               len = MAX_LEN;
            else
               len = LEN_W'($urandom_range(HEADER_BYTES, int'(MAX_LEN)));
            queue_item(FUNC_FRAME, addr, len);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   logic [TTL_W-1:0] reload_plan [8];

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_ch.valid          = 1'b0;
      req_ch.func           = FUNC_FRAME;
      req_ch.source_address = '0;
      req_ch.frame_length   = '0;
      rsp_ch.ready          = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_valid[i]  = 1'b0;
         shadow_online[i] = 1'b0;
         shadow_addr[i]   = '0;
         shadow_ttl[i]    = '0;
      end
      shadow_ptr    = 0;
      shadow_reload = TTL_RESET;
      mismatches    = 0;
      n_frames      = 0;
      n_short       = 0;
      n_hits        = 0;
      n_ticks       = 0;
      n_wraps       = 0;
      n_checked     = 0;
      n_settings    = 1;  // reset value counts as the first setting

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, reset reload: address extremes, length boundaries, ignored payloads
      queue_item(FUNC_FRAME, '0, HDR_LEN);
      queue_item(FUNC_FRAME, '1, MAX_LEN);
      queue_item(FUNC_FRAME, '0, MAX_LEN);                              // hit
      queue_item(FUNC_FRAME, 48'h0123_4567_89AB, '0);                   // runt
      queue_item(FUNC_FRAME, 48'hFEDC_BA98_7654, HDR_LEN - LEN_W'(1));  // one byte short
      queue_item(FUNC_TICK, '1, MAX_LEN);
      queue_item(FUNC_TICK, '0, '0);
      queue_item(FUNC_FRAME, 48'hAAAA_5555_AAAA, HDR_LEN);
      queue_item(FUNC_FRAME, 48'h5555_AAAA_5555, HDR_LEN + LEN_W'(1));
      wait_until_drained();

      // unmapped write must leave ttl_reload alone; then reload of one expires on the next tick
      set_register(REG_UNMAPPED, 16'h0003);
      set_register(REG_TTL_RELOAD, 16'd1);
      queue_item(FUNC_FRAME, '0, HDR_LEN);
      queue_item(FUNC_TICK, '0, '0);
      queue_item(FUNC_TICK, '1, '1);
      queue_item(FUNC_FRAME, '1, MAX_LEN);
      wait_until_drained();

      // zero reload is taken as is: offline at the very next tick
      set_register(REG_TTL_RELOAD, '0);
      queue_item(FUNC_FRAME, 48'h0000_0000_0001, HDR_LEN);
      queue_item(FUNC_TICK, '0, '0);
      queue_item(FUNC_FRAME, 48'h0000_0000_0001, HDR_LEN);
      queue_item(FUNC_TICK, '0, '0);
      wait_until_drained();

      // random phases over a spread of reload values, extremes included
      reload_plan = '{16'd2, 16'hFFFF, 16'd5, 16'd1, 16'd0, 16'd3, 16'd8, TTL_RESET};
      reload_plan[6] = TTL_W'($urandom_range(2, 12));
      foreach (reload_plan[p]) begin
         set_register(REG_TTL_RELOAD, reload_plan[p]);
         queue_random_items(PHASE_ITEMS);
         wait_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_status.size() != 0)
         report_mismatch("responses never returned", 64'(expected_status.size()), 64'd0);

      $display("covered %0d accepted frames (%0d table hits), %0d runt frames, %0d ticks, %0d wraps",
               n_frames, n_hits, n_short, n_ticks, n_wraps);
      $display("%0d responses checked across %0d ttl_reload settings, %0d mismatches",
               n_checked, n_settings, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
